// ===== rtl/subleq_machine_step_assert.svh =====
// ----------------------------------------------------------------------------
// Subleq machine step assertion macros
// Short forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef SUBLEQ_MACHINE_STEP_ASSERT_SVH
`define SUBLEQ_MACHINE_STEP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("subleq_machine_step: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("subleq_machine_step: next-cycle check failed");

`endif

// ===== rtl/sms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subleq machine step package
// Widths, command and fault codes, request/response types, operand checks.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int IP_W      = 10;
   localparam int IP_SPAN   = 2 ** IP_W;
   localparam int WORD_W    = 32;
   localparam int CHAR_W    = 9;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_EXEC    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_IP      = 2'd1;
   localparam logic [1:0] FAULT_OPERAND = 2'd2;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [IP_W-1:0]          load_addr;
      logic signed [WORD_W-1:0] load_data;
      logic signed [CHAR_W-1:0] in_char;
   } req_type;

   typedef struct packed {
      logic            out_valid;
      logic [7:0]      out_char;
      logic            in_used;
      logic            halted;
      logic [1:0]      fault;
      logic [IP_W-1:0] current_ip;
   } rsp_type;

   // nonnegative operand that does not address a memory word
   function automatic logic addr_bad(input logic [WORD_W-1:0] w);
      return !w[WORD_W-1] && (w >= WORD_W'(MEM_WORDS));
   endfunction

   // branch target must also fit the pointer
   function automatic logic target_bad(input logic [WORD_W-1:0] w);
      return !w[WORD_W-1] && ((w >= WORD_W'(MEM_WORDS)) || (w >= WORD_W'(IP_SPAN)));
   endfunction

endpackage

// ===== rtl/sms_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subleq machine step channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sms_req_if;
   import sms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic [IP_W-1:0]          load_addr;
   logic signed [WORD_W-1:0] load_data;
   logic signed [CHAR_W-1:0] in_char;

   modport source (output valid, cmd, load_addr, load_data, in_char, input ready);
   modport sink   (input valid, cmd, load_addr, load_data, in_char, output ready);
endinterface

interface sms_rsp_if;
   import sms_pkg::*;

   logic            valid;
   logic            ready;
   logic            out_valid;
   logic [7:0]      out_char;
   logic            in_used;
   logic            halted;
   logic [1:0]      fault;
   logic [IP_W-1:0] current_ip;

   modport source (output valid, out_valid, out_char, in_used, halted, fault, current_ip,
                   input ready);
   modport sink   (input valid, out_valid, out_char, in_used, halted, fault, current_ip,
                   output ready);
endinterface

// ===== rtl/sms_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subleq machine step response buffer
// Two-entry queue between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module sms_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sms_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_vld,
   input  logic             out_rdy,
   output sms_pkg::rsp_type out_data
);
   import sms_pkg::*;

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign full     = (cnt_ff == 2'd2);
   assign out_vld  = (cnt_ff != 2'd0);
   assign out_data = ent_ff[rd_ptr_ff];
   assign pop      = out_vld && out_rdy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/sms_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subleq machine step sequencer
// Word memory, machine registers and the read-modify-write sequence.
// ----------------------------------------------------------------------------
module sms_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [sms_pkg::IP_W-1:0] csr_wdata,
   input  logic                    item_vld,
   input  sms_pkg::req_type        item,
   input  logic                    room,
   output logic                    take,
   output logic                    done,
   output sms_pkg::rsp_type        result
);
   import sms_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RD_B   = 3'd1;
   localparam logic [2:0] ST_RD_C   = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_RD_MIN = 3'd4;
   localparam logic [2:0] ST_EXEC   = 3'd5;

   logic [WORD_W-1:0]        mem [MEM_WORDS];
   logic [WORD_W-1:0]        rdata_ff;
   logic [ADDR_W-1:0]        mem_addr;
   logic                     mem_we;
   logic [WORD_W-1:0]        mem_wdata;

   logic [2:0]               state_ff, state_in;
   logic [IP_W-1:0]          ip_ff, ip_in;
   logic                     stop_ff, stop_in;
   logic [1:0]               fault_ff, fault_in;
   logic [IP_W-1:0]          start_ff;
   logic [WORD_W-1:0]        a_ff, a_in;
   logic [WORD_W-1:0]        b_ff, b_in;
   logic [WORD_W-1:0]        c_ff, c_in;
   logic [WORD_W-1:0]        min_ff, min_in;
   logic signed [CHAR_W-1:0] char_ff, char_in;

   logic [WORD_W-1:0]        ip_ext;
   logic [WORD_W-1:0]        char_ext;
   logic [WORD_W-1:0]        subtr;
   logic [WORD_W-1:0]        diff;
   logic [WORD_W-1:0]        diff_neg;
   logic [IP_W:0]            ip_step;

   assign ip_ext   = WORD_W'(ip_ff);
   assign char_ext = {{(WORD_W-CHAR_W){char_ff[CHAR_W-1]}}, char_ff};
   assign subtr    = a_ff[WORD_W-1] ? (WORD_W'(0) - char_ext) : rdata_ff;
   assign diff     = min_ff - subtr;
   assign diff_neg = WORD_W'(0) - diff;
   assign ip_step  = {1'b0, ip_ff} + (IP_W+1)'(3);

   always_comb begin
      state_in  = state_ff;
      ip_in     = ip_ff;
      stop_in   = stop_ff;
      fault_in  = fault_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      min_in    = min_ff;
      char_in   = char_ff;
      mem_addr  = ADDR_W'(ip_ext);
      mem_we    = 1'b0;
      mem_wdata = diff;
      take      = 1'b0;
      done      = 1'b0;
      result    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_vld && room) begin
               take = 1'b1;
               unique case (item.cmd)
                  CMD_LOAD: begin
                     done = 1'b1;
                     if (WORD_W'(item.load_addr) < WORD_W'(MEM_WORDS)) begin
                        mem_we    = 1'b1;
                        mem_addr  = ADDR_W'(item.load_addr);
                        mem_wdata = item.load_data;
                     end
                  end
                  CMD_EXEC: begin
                     if (stop_ff) begin
                        done = 1'b1;
                     end else if (ip_ext + WORD_W'(2) >= WORD_W'(MEM_WORDS)) begin
                        stop_in  = 1'b1;
                        fault_in = FAULT_IP;
                        done     = 1'b1;
                     end else begin
                        mem_addr = ADDR_W'(ip_ext);
                        char_in  = item.in_char;
                        state_in = ST_RD_B;
                     end
                  end
                  CMD_RESTART: begin
                     ip_in    = start_ff;
                     stop_in  = 1'b0;
                     fault_in = FAULT_NONE;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_B: begin
            a_in     = rdata_ff;
            mem_addr = ADDR_W'(ip_ext + WORD_W'(1));
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            b_in     = rdata_ff;
            mem_addr = ADDR_W'(ip_ext + WORD_W'(2));
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            c_in = rdata_ff;
            if (addr_bad(a_ff) || addr_bad(b_ff) || target_bad(rdata_ff)) begin
               stop_in  = 1'b1;
               fault_in = FAULT_OPERAND;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // address is harmless when b is negative; the data is dropped
               mem_addr = ADDR_W'(b_ff);
               state_in = ST_RD_MIN;
            end
         end
         ST_RD_MIN: begin
            min_in   = b_ff[WORD_W-1] ? '0 : rdata_ff;
            mem_addr = ADDR_W'(a_ff);
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            mem_addr = ADDR_W'(b_ff);
            mem_we   = !b_ff[WORD_W-1];
            result.out_valid = b_ff[WORD_W-1];
            result.out_char  = b_ff[WORD_W-1] ? diff_neg[7:0] : 8'd0;
            result.in_used   = a_ff[WORD_W-1];
            if ((diff == '0) || diff[WORD_W-1]) begin
               if (c_ff[WORD_W-1]) begin
                  stop_in = 1'b1;
               end else begin
                  ip_in = c_ff[IP_W-1:0];
               end
            end else if (ip_step[IP_W]) begin
               stop_in  = 1'b1;
               fault_in = FAULT_IP;
            end else begin
               ip_in = ip_step[IP_W-1:0];
            end
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.halted     = stop_in;
      result.fault      = fault_in;
      result.current_ip = ip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ip_ff    <= '0;
         stop_ff  <= 1'b0;
         fault_ff <= FAULT_NONE;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         ip_ff    <= ip_in;
         stop_ff  <= stop_in;
         fault_ff <= fault_in;
         if (csr_we) begin
            start_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      min_ff  <= min_in;
      char_ff <= char_in;
   end

   // single-port word memory, read-first
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end
endmodule

// ===== rtl/subleq_machine_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subleq machine step
// One-instruction machine with a loadable word memory, one response per request.
// ----------------------------------------------------------------------------
// Each request gives exactly one response. Load, restart, unused-command and
// halted-execute requests complete in the cycle they are taken, as does an
// execute whose pointer leaves no room for three words. An execute with an
// operand out of range stops once a, b and c have been read and checked. A full
// execute is sequenced by the single-port word memory: three reads for a, b
// and c, one for mem[b], one for mem[a], and the write-back of the difference
// in the final EXEC state. A request is held in a one-deep input register while the
// previous one is still running. Responses queue in a two-entry buffer; when it
// is full the sequencer takes no new request and the request side stalls. The
// word memory is not cleared by reset; reading a word that was never loaded
// returns an arbitrary value.
module subleq_machine_step (
   input  logic                     clock,
   input  logic                     reset,
   sms_req_if.sink                  req_ch,
   sms_rsp_if.source                rsp_ch,
   input  logic                     csr_we,
   input  logic [sms_pkg::IP_W-1:0] csr_wdata
);
   import sms_pkg::*;

   logic    hold_vld_ff, hold_vld_in;
   req_type hold_ff, hold_in;
   logic    req_acc;
   logic    core_take;
   logic    core_done;
   rsp_type core_rsp;
   logic    rsp_full;
   rsp_type rsp_data;

   assign req_ch.ready = !hold_vld_ff || core_take;
   assign req_acc      = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      if (req_acc) begin
         hold_in.cmd       = req_ch.cmd;
         hold_in.load_addr = req_ch.load_addr;
         hold_in.load_data = req_ch.load_data;
         hold_in.in_char   = req_ch.in_char;
         hold_vld_in       = 1'b1;
      end else if (core_take) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   sms_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item_vld  (hold_vld_ff),
      .item      (hold_ff),
      .room      (!rsp_full),
      .take      (core_take),
      .done      (core_done),
      .result    (core_rsp)
   );

   sms_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (core_done),
      .push_data (core_rsp),
      .full      (rsp_full),
      .out_vld   (rsp_ch.valid),
      .out_rdy   (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.out_valid  = rsp_data.out_valid;
   assign rsp_ch.out_char   = rsp_data.out_char;
   assign rsp_ch.in_used    = rsp_data.in_used;
   assign rsp_ch.halted     = rsp_data.halted;
   assign rsp_ch.fault      = rsp_data.fault;
   assign rsp_ch.current_ip = rsp_data.current_ip;

`include "subleq_machine_step_assert.svh"

   `SMS_ASSERT_NEXT(a_req_held, clock, reset, req_acc, hold_vld_ff)
   `SMS_ASSERT_NOW(a_take_held, clock, reset, core_take, hold_vld_ff)
   `SMS_ASSERT_NOW(a_rsp_room, clock, reset, core_done, !rsp_full)

endmodule
